### rtl/apr_pkg.sv
// ----------------------------------------------------------------------------
// Audio level meter package
// Shared widths, constants and the run snapshot passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package apr_pkg;

  localparam int SampleBits = 24;
  localparam int ThrW       = 24;
  localparam logic [ThrW-1:0] ThrReset = 24'd8304722;

  // Squares are kept with 30 fractional bits.
  localparam int SqFrac = 30;
  localparam int FullFrac = 2 * (SampleBits - 1);
  localparam int SqRsh = (FullFrac >= SqFrac) ? FullFrac - SqFrac : 0;
  localparam int SqLsh = (FullFrac >= SqFrac) ? 0 : SqFrac - FullFrac;
  localparam int SqW   = 2 * SampleBits - SqRsh + SqLsh;

  localparam int SumW = 64;
  localparam int CntW = 32;

  // log2 results: 6 integer bits, 16 fraction bits.
  localparam int TopW = 6;
  localparam int FracW = 16;
  localparam int LogW = TopW + FracW;

  // Signed level in Q.16 and dB conversion.
  localparam int LvlW  = 24;
  localparam int NegW  = LvlW - 1;
  localparam int KW    = 27;
  localparam int ProdW = NegW + KW;
  localparam logic [KW-1:0] DbK = 27'd101008905;

  localparam int DbW = 17;
  localparam logic signed [DbW-1:0] DbSilent = -17'sd25600;
  localparam logic signed [DbW-1:0] DbFloor  = -17'sd40960;
  localparam int DbFloorMag = 40960;

  typedef struct packed {
    logic [SampleBits-1:0] peak;
    logic [SumW-1:0]       sum;
    logic [CntW-1:0]       total;
    logic [CntW-1:0]       clipped;
    logic                  overflow;
  } snap_t;

  typedef enum logic [1:0] {
    OP_PEAK = 2'd0,
    OP_SUM  = 2'd1,
    OP_TOT  = 2'd2
  } op_e;

endpackage

`default_nettype wire

### rtl/audio_peak_rms_clip_meter.sv
// ----------------------------------------------------------------------------
// Audio peak, RMS and clip level meter
// Measures a run of Q1.23 samples and reports levels in Q9.8 dB.
// ----------------------------------------------------------------------------
// Samples enter through a queue-like port: a transfer happens on a clock edge
// with push high and full low. Each sample is squared in one stage and added
// to the run totals in the next, so one sample per cycle is taken while full
// is low. The sample flagged last closes the run: its totals go into a
// two-entry queue and the accumulators clear, so the next run may start in
// the following cycle. The back end takes one snapshot at a time and runs up
// to three log2 operations on a shared unit. Each normalizes its operand one
// bit at a time, up to 63 bits of shift, then squares once for each of the
// 16 fraction bits; that unit sets the rate of results. A result waits on
// the output ports while empty is low and leaves on a transfer with pop high.
// While the reader stalls, the back end holds its next result, and the front
// end only sets full when a last sample finds both queue entries taken.
// Reset clears all run totals and the queue, empties the output and loads
// the clip threshold with 0.99 full scale. The user must write the threshold
// through cfg_we_i only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_rms_clip_meter import apr_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output      logic                         full,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic                         last_i,
  output      logic                         empty,
  input  wire logic                         pop,
  output      logic signed [DbW-1:0]        peak_db_o,
  output      logic signed [DbW-1:0]        rms_db_o,
  output      logic [CntW-1:0]              clips_o,
  output      logic                         clip_flag_o,
  output      logic                         count_saturated_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [ThrW-1:0]              cfg_wdata_i
);

  logic  snap_wr, snap_full, snap_rd, snap_empty;
  snap_t snap_in, snap_out;

  // Front end: squares and accumulates.
  apr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .snap_wr_o   (snap_wr),
    .snap_o      (snap_in),
    .snap_full_i (snap_full)
  );

  // Run totals wait here while the back end is busy.
  apr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (snap_wr),
    .data_i  (snap_in),
    .full_o  (snap_full),
    .rd_i    (snap_rd),
    .data_o  (snap_out),
    .empty_o (snap_empty)
  );

  // Back end: logarithms, dB scaling and the result register.
  apr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .snap_i            (snap_out),
    .snap_empty_i      (snap_empty),
    .snap_rd_o         (snap_rd),
    .empty_o           (empty),
    .pop_i             (pop),
    .peak_db_o         (peak_db_o),
    .rms_db_o          (rms_db_o),
    .clips_o           (clips_o),
    .clip_flag_o       (clip_flag_o),
    .count_saturated_o (count_saturated_o)
  );

endmodule

`default_nettype wire

### rtl/apr_front.sv
// ----------------------------------------------------------------------------
// Level meter front end
// Takes samples, squares them and accumulates the run statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_front import apr_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  output      logic                         full_o,
  input  wire logic signed [SampleBits-1:0] sample_i,
  input  wire logic                         last_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [ThrW-1:0]              cfg_wdata_i,
  output      logic                         snap_wr_o,
  output      snap_t                        snap_o,
  input  wire logic                         snap_full_i
);

  logic [ThrW-1:0] thr_q;

  logic                  v1_q, last1_q, clip1_q;
  logic [SampleBits-1:0] mag1_q;
  logic [SqW-1:0]        sq1_q;

  logic [SampleBits-1:0] peak_q, peak_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [CntW-1:0]       tot_q, tot_d, clp_q, clp_d;
  logic                  ovf_q, ovf_d;

  logic                  stall, accept, fire;
  logic [SampleBits-1:0] mag;
  logic [63:0]           sq_full;
  logic                  clip;
  logic [SumW:0]         sum_ext;

  always_comb begin
    mag = sample_i[SampleBits-1] ? SampleBits'(-sample_i) : SampleBits'(sample_i);
    sq_full = (64'(mag) * 64'(mag)) >> SqRsh;
    clip = ((64'(mag) << 23) >= (64'(thr_q) << (SampleBits - 1)));
  end

  assign stall  = v1_q & last1_q & snap_full_i;
  assign full_o = stall;
  assign accept = push_i & ~stall;
  assign fire   = v1_q & ~stall;

  always_comb begin
    peak_d  = (mag1_q > peak_q) ? mag1_q : peak_q;
    sum_ext = {1'b0, sum_q} + (SumW+1)'(sq1_q);
    sum_d   = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
    tot_d   = (tot_q == '1) ? tot_q : tot_q + CntW'(1);
    ovf_d   = ovf_q | (tot_q == '1);
    clp_d   = (clip1_q && clp_q != '1) ? clp_q + CntW'(1) : clp_q;
  end

  assign snap_wr_o = fire & last1_q;
  always_comb begin
    snap_o.peak     = peak_d;
    snap_o.sum      = sum_d;
    snap_o.total    = tot_d;
    snap_o.clipped  = clp_d;
    snap_o.overflow = ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Square stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (!stall) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      last1_q <= last_i;
      clip1_q <= clip;
      mag1_q  <= mag;
      sq1_q   <= SqW'(sq_full << SqLsh);
    end
  end

  // Accumulate stage; a last sample hands the totals over and clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sum_q  <= '0;
      tot_q  <= '0;
      clp_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (fire) begin
      if (last1_q) begin
        peak_q <= '0;
        sum_q  <= '0;
        tot_q  <= '0;
        clp_q  <= '0;
        ovf_q  <= 1'b0;
      end else begin
        peak_q <= peak_d;
        sum_q  <= sum_d;
        tot_q  <= tot_d;
        clp_q  <= clp_d;
        ovf_q  <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/apr_fifo.sv
// ----------------------------------------------------------------------------
// Level meter snapshot queue
// Two-entry queue of run totals between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_fifo import apr_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  wr_i,
  input  wire snap_t data_i,
  output      logic  full_o,
  input  wire logic  rd_i,
  output      snap_t data_o,
  output      logic  empty_o
);

  snap_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o) else $error("snapshot queue written while full");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> !empty_o) else $error("snapshot queue read while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("snapshot queue count did not follow a write");
`endif

endmodule

`default_nettype wire

### rtl/apr_log2.sv
// ----------------------------------------------------------------------------
// Level meter log2 unit
// Normalizes one bit a cycle, then squares once per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_log2 import apr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SumW-1:0]   value_i,
  output      logic              busy_o,
  output      logic              done_o,
  output      logic [LogW-1:0]   result_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_ITER = 3'b100
  } lstate_e;

  lstate_e          st_q;
  logic [SumW-1:0]  v_q;
  logic [TopW-1:0]  top_q;
  logic [FracW-1:0] frac_q;
  logic [3:0]       bit_q;
  logic [31:0]      y_q;
  logic             done_q;
  logic [63:0]      prod;

  assign prod     = 64'(y_q) * 64'(y_q);
  assign busy_o   = (st_q != L_IDLE);
  assign done_o   = done_q;
  assign result_o = {top_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        L_IDLE: if (start_i) st_q <= L_NORM;
        L_NORM: if (v_q[SumW-1]) st_q <= L_ITER;
        L_ITER: begin
          if (bit_q == 4'd0) begin
            st_q   <= L_IDLE;
            done_q <= 1'b1;
          end
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      L_IDLE: begin
        v_q    <= value_i;
        top_q  <= TopW'(SumW - 1);
        frac_q <= '0;
        bit_q  <= 4'd15;
      end
      L_NORM: begin
        if (v_q[SumW-1]) begin
          y_q <= v_q[SumW-1:SumW-32];
        end else begin
          v_q   <= v_q << 1;
          top_q <= top_q - TopW'(1);
        end
      end
      L_ITER: begin
        // A square of two or more sets this bit and is halved.
        if (prod[63]) begin
          frac_q[bit_q] <= 1'b1;
          y_q <= prod[63:32];
        end else begin
          y_q <= prod[62:31];
        end
        bit_q <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/apr_back.sv
// ----------------------------------------------------------------------------
// Level meter back end
// Turns run totals into dB levels and holds the result for the reader.
// ----------------------------------------------------------------------------
`default_nettype none

module apr_back import apr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire snap_t                 snap_i,
  input  wire logic                  snap_empty_i,
  output      logic                  snap_rd_o,
  output      logic                  empty_o,
  input  wire logic                  pop_i,
  output      logic signed [DbW-1:0] peak_db_o,
  output      logic signed [DbW-1:0] rms_db_o,
  output      logic [CntW-1:0]       clips_o,
  output      logic                  clip_flag_o,
  output      logic                  count_saturated_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_START = 8'b00000010,
    S_RUN   = 8'b00000100,
    S_DBP   = 8'b00001000,
    S_DBP2  = 8'b00010000,
    S_DBR   = 8'b00100000,
    S_DBR2  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_e;

  localparam int PeakOff = (SampleBits - 1) * 65536;
  localparam int RmsOff  = SqFrac * 65536;

  state_e                st_q;
  op_e                   op_q;
  snap_t                 snap_q;
  logic [LogW-1:0]       lp_q, ls_q, lt_q;
  logic [ProdW-1:0]      prod_q;
  logic signed [DbW-1:0] pdb_q, rdb_q;
  logic                  out_v_q;

  logic                  log_start, log_busy, log_done;
  logic [SumW-1:0]       log_val;
  logic [LogW-1:0]       log_res;
  logic signed [LvlW-1:0] lvl_p, lvl_r;
  logic [NegW-1:0]       neg_p, neg_r;
  logic                  load_out;

  function automatic logic signed [DbW-1:0] to_db(input logic [ProdW-1:0] p,
                                                  input logic shift33);
    logic [ProdW:0] s;
    logic [ProdW:0] r;
    s = shift33 ? ({1'b0, p} + ((ProdW+1)'(1) << 32))
                : ({1'b0, p} + ((ProdW+1)'(1) << 31));
    r = shift33 ? (s >> 33) : (s >> 32);
    if (r >= (ProdW+1)'(DbFloorMag)) begin
      return DbFloor;
    end
    return -$signed(DbW'(r));
  endfunction

  apr_log2 u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .value_i  (log_val),
    .busy_o   (log_busy),
    .done_o   (log_done),
    .result_o (log_res)
  );

  always_comb begin
    log_val = snap_q.sum;
    case (op_q)
      OP_PEAK: log_val = SumW'(snap_q.peak);
      OP_TOT:  log_val = SumW'(snap_q.total);
      default: log_val = snap_q.sum;
    endcase
  end

  assign log_start = (st_q == S_START) &&
                     !(op_q == OP_PEAK && snap_q.peak == '0) &&
                     !(op_q == OP_SUM && snap_q.sum == '0);

  always_comb begin
    lvl_p = $signed({2'b00, lp_q}) - $signed(LvlW'(PeakOff));
    lvl_r = $signed({2'b00, ls_q}) - $signed({2'b00, lt_q}) - $signed(LvlW'(RmsOff));
    neg_p = lvl_p[LvlW-1] ? NegW'(-lvl_p) : '0;
    neg_r = lvl_r[LvlW-1] ? NegW'(-lvl_r) : '0;
  end

  assign snap_rd_o = (st_q == S_IDLE) && !snap_empty_i;
  assign load_out  = (st_q == S_OUT) && (!out_v_q || pop_i);
  assign empty_o   = ~out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      op_q    <= OP_PEAK;
      out_v_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (!snap_empty_i) begin
            st_q <= S_START;
            op_q <= OP_PEAK;
          end
        end
        S_START: begin
          if (log_start) begin
            st_q <= S_RUN;
          end else if (op_q == OP_PEAK) begin
            op_q <= OP_SUM;
          end else begin
            st_q <= S_DBP;
          end
        end
        S_RUN: begin
          if (log_done) begin
            case (op_q)
              OP_PEAK: begin
                op_q <= OP_SUM;
                st_q <= S_START;
              end
              OP_SUM: begin
                op_q <= OP_TOT;
                st_q <= S_START;
              end
              default: st_q <= S_DBP;
            endcase
          end
        end
        S_DBP:  st_q <= S_DBP2;
        S_DBP2: st_q <= S_DBR;
        S_DBR:  st_q <= S_DBR2;
        S_DBR2: st_q <= S_OUT;
        S_OUT:  if (load_out) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_rd_o) begin
      snap_q <= snap_i;
    end
    if (st_q == S_RUN && log_done) begin
      case (op_q)
        OP_PEAK: lp_q <= log_res;
        OP_SUM:  ls_q <= log_res;
        default: lt_q <= log_res;
      endcase
    end
    if (st_q == S_DBP) prod_q <= ProdW'(neg_p) * ProdW'(DbK);
    if (st_q == S_DBR) prod_q <= ProdW'(neg_r) * ProdW'(DbK);
    if (st_q == S_DBP2) begin
      pdb_q <= (snap_q.peak == '0) ? DbSilent : to_db(prod_q, 1'b0);
    end
    if (st_q == S_DBR2) begin
      rdb_q <= (snap_q.sum == '0) ? DbSilent : to_db(prod_q, 1'b1);
    end
    if (load_out) begin
      peak_db_o         <= pdb_q;
      rms_db_o          <= rdb_q;
      clips_o           <= snap_q.clipped;
      clip_flag_o       <= (snap_q.clipped != '0);
      count_saturated_o <= snap_q.overflow;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_start |-> !log_busy) else $error("log2 started while busy");
  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> st_q == S_RUN) else $error("log2 finished outside a run");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pop_i) |=> out_v_q && $stable(rms_db_o))
    else $error("held result changed");
`endif

endmodule

`default_nettype wire
